FILE: design/pes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle step package
// Shared types, register map, reset values and fixed point helpers.
// ----------------------------------------------------------------------------
package pes_pkg;

   typedef logic signed [31:0] q_type;

   typedef enum logic [1:0] {
      REG_TIME_STEP    = 2'd0,
      REG_GRAVITY      = 2'd1,
      REG_FIELD_WIDTH  = 2'd2,
      REG_FIELD_HEIGHT = 2'd3
   } csr_index_type;

   localparam int unsigned PADDR_W = 4;
   localparam int unsigned NSTG    = 9;

   localparam logic [15:0] TIME_STEP_RST    = 16'd1092;
   localparam logic [23:0] GRAVITY_RST      = 24'd250880;
   localparam logic [15:0] FIELD_WIDTH_RST  = 16'd1024;
   localparam logic [15:0] FIELD_HEIGHT_RST = 16'd768;

   // 46341 / 65536 approximates 1/sqrt(2); the sign folds in the reversal.
   localparam logic signed [16:0] NEG_INV_SQRT2 = -17'sd46341;

   // Rounds a Q16 product to nearest, ties toward plus infinity.
   function automatic logic signed [33:0] round_q16(input logic signed [48:0] p);
      logic signed [49:0] y;
      y = {p[48], p} + 50'sd32768;
      return y[49:16];
   endfunction

   function automatic q_type sat32(input logic signed [33:0] x);
      if (x > 34'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (x < -34'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

endpackage

FILE: design/pes_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle record channel
// Valid/ready channel that carries one particle state per transfer.
// ----------------------------------------------------------------------------
interface pes_req_if
   import pes_pkg::*;
();
   logic        valid;
   logic        ready;
   q_type       pos_x;
   q_type       pos_y;
   q_type       vel_x;
   q_type       vel_y;
   q_type       acc_x;
   q_type       acc_y;
   logic [15:0] radius;

   modport source (
      output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, radius,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, radius,
      output ready
   );
endinterface

FILE: design/pes_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle result channel
// Valid/ready channel that carries one updated particle state per transfer.
// ----------------------------------------------------------------------------
interface pes_rsp_if
   import pes_pkg::*;
();
   logic       valid;
   logic       ready;
   q_type      new_pos_x;
   q_type      new_pos_y;
   q_type      new_vel_x;
   q_type      new_vel_y;
   logic [3:0] wall_hits;

   modport source (
      output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, wall_hits,
      input  ready
   );
   modport sink (
      input  valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, wall_hits,
      output ready
   );
endinterface

FILE: design/particle_euler_step_wall_bounce_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle Euler step with wall bounce
// Semi-implicit Euler update of one particle per transfer, followed by
// clamping against the four field walls with a damped velocity reversal.
// ----------------------------------------------------------------------------
// Particle records enter on req_ch and updated records leave on rsp_ch, both
// valid/ready channels; a transfer happens when valid and ready are high.
// Time step, gravity and field size are written through the APB port and
// should only change while no particle is in flight.
// The datapath is a nine stage pipeline: gravity add, acceleration products,
// velocity update, velocity products, position update, wall clamp with the
// first bounce product, first bounce rounding, second bounce product and
// final selection. One particle can be taken every cycle while rsp_ch is
// not stalled; the multipliers are the units that set the stage split.
// Each stage holds its data while the next one is full and stalled, so a
// stall on rsp_ch fills empty stages first and then lowers req_ch.ready.
// Reset empties the pipeline and loads the default register values.
// ----------------------------------------------------------------------------
module particle_euler_step_wall_bounce_core
   import pes_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   pes_req_if.sink            req_ch,
   pes_rsp_if.source          rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [15:0] time_step_ff;
   logic [23:0] gravity_ff;
   logic [15:0] field_width_ff;
   logic [15:0] field_height_ff;
   logic        csr_wr;

   logic [NSTG:1]   valid_ff;
   logic [NSTG+1:1] adv;

   logic signed [16:0] dt;
   logic signed [31:0] right_lim;
   logic signed [31:0] bottom_lim;
   logic [23:0]        right_wall;
   logic [23:0]        bottom_wall;

   // Stage 1: gravity applied.
   q_type       s1_px_ff, s1_py_ff, s1_vx_ff, s1_vy_ff, s1_ax_ff, s1_ay_ff;
   logic [15:0] s1_r_ff;
   q_type       s1_ay_in;
   // Stage 2: acceleration products.
   q_type              s2_px_ff, s2_py_ff, s2_vx_ff, s2_vy_ff;
   logic [15:0]        s2_r_ff;
   logic signed [48:0] s2_pax_ff, s2_pay_ff;
   // Stage 3: velocity updated.
   q_type       s3_px_ff, s3_py_ff, s3_vx_ff, s3_vy_ff;
   logic [15:0] s3_r_ff;
   q_type       s3_vx_in, s3_vy_in;
   // Stage 4: velocity products.
   q_type              s4_px_ff, s4_py_ff, s4_vx_ff, s4_vy_ff;
   logic [15:0]        s4_r_ff;
   logic signed [48:0] s4_pvx_ff, s4_pvy_ff;
   // Stage 5: position updated.
   q_type       s5_px_ff, s5_py_ff, s5_vx_ff, s5_vy_ff;
   logic [15:0] s5_r_ff;
   q_type       s5_px_in, s5_py_in;
   // Stage 6: walls clamped, first bounce product.
   q_type              s6_px_ff, s6_py_ff, s6_vx_ff, s6_vy_ff;
   logic [3:0]         s6_hits_ff;
   logic signed [48:0] s6_bx_ff, s6_by_ff;
   q_type              s6_px_in, s6_py_in;
   logic [3:0]         s6_hits_in;
   q_type              px1, py1;
   // Stage 7: first bounce rounded.
   q_type      s7_px_ff, s7_py_ff, s7_vx_ff, s7_vy_ff, s7_b1x_ff, s7_b1y_ff;
   logic [3:0] s7_hits_ff;
   // Stage 8: second bounce product.
   q_type              s8_px_ff, s8_py_ff, s8_vx_ff, s8_vy_ff, s8_b1x_ff, s8_b1y_ff;
   logic [3:0]         s8_hits_ff;
   logic signed [48:0] s8_bbx_ff, s8_bby_ff;
   // Stage 9: result.
   q_type      s9_px_ff, s9_py_ff, s9_vx_ff, s9_vy_ff;
   logic [3:0] s9_hits_ff;
   q_type      s9_vx_in, s9_vy_in;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff    <= TIME_STEP_RST;
         gravity_ff      <= GRAVITY_RST;
         field_width_ff  <= FIELD_WIDTH_RST;
         field_height_ff <= FIELD_HEIGHT_RST;
      end else if (csr_wr) begin
         case (csr_index_type'(paddr[3:2]))
            REG_TIME_STEP:    time_step_ff    <= pwdata[15:0];
            REG_GRAVITY:      gravity_ff      <= pwdata[23:0];
            REG_FIELD_WIDTH:  field_width_ff  <= pwdata[15:0];
            REG_FIELD_HEIGHT: field_height_ff <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(paddr[3:2]))
         REG_TIME_STEP:    prdata = {16'd0, time_step_ff};
         REG_GRAVITY:      prdata = {8'd0, gravity_ff};
         REG_FIELD_WIDTH:  prdata = {16'd0, field_width_ff};
         REG_FIELD_HEIGHT: prdata = {16'd0, field_height_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------------
   always_comb begin
      adv[NSTG+1] = rsp_ch.ready;
      for (int k = NSTG; k >= 1; k--) begin
         adv[k] = ~valid_ff[k] | adv[k+1];
      end
   end

   assign req_ch.ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) begin
            valid_ff[1] <= req_ch.valid;
         end
         for (int k = 2; k <= NSTG; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign dt          = $signed({1'b0, time_step_ff});
   assign right_wall  = {field_width_ff, 8'd0};
   assign bottom_wall = {field_height_ff, 8'd0};

   // ------------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------------
   always_comb begin
      s1_ay_in = sat32({{2{req_ch.acc_y[31]}}, req_ch.acc_y}
                       + {{10{gravity_ff[23]}}, gravity_ff});

      s3_vx_in = sat32({{2{s2_vx_ff[31]}}, s2_vx_ff} + round_q16(s2_pax_ff));
      s3_vy_in = sat32({{2{s2_vy_ff[31]}}, s2_vy_ff} + round_q16(s2_pay_ff));

      s5_px_in = sat32({{2{s4_px_ff[31]}}, s4_px_ff} + round_q16(s4_pvx_ff));
      s5_py_in = sat32({{2{s4_py_ff[31]}}, s4_py_ff} + round_q16(s4_pvy_ff));

      right_lim  = $signed({8'd0, right_wall}) - $signed({16'd0, s5_r_ff});
      bottom_lim = $signed({8'd0, bottom_wall}) - $signed({16'd0, s5_r_ff});

      s6_hits_in[0] = $signed({{2{s5_px_ff[31]}}, s5_px_ff}) < $signed({18'd0, s5_r_ff});
      px1 = s6_hits_in[0] ? $signed({16'd0, s5_r_ff}) : s5_px_ff;
      s6_hits_in[1] = ($signed({{2{px1[31]}}, px1}) + $signed({18'd0, s5_r_ff}))
                      > $signed({10'd0, right_wall});
      s6_px_in = s6_hits_in[1] ? right_lim : px1;

      s6_hits_in[2] = $signed({{2{s5_py_ff[31]}}, s5_py_ff}) < $signed({18'd0, s5_r_ff});
      py1 = s6_hits_in[2] ? $signed({16'd0, s5_r_ff}) : s5_py_ff;
      s6_hits_in[3] = ($signed({{2{py1[31]}}, py1}) + $signed({18'd0, s5_r_ff}))
                      > $signed({10'd0, bottom_wall});
      s6_py_in = s6_hits_in[3] ? bottom_lim : py1;

      case (s8_hits_ff[1:0])
         2'b00:   s9_vx_in = s8_vx_ff;
         2'b11:   s9_vx_in = sat32(round_q16(s8_bbx_ff));
         default: s9_vx_in = s8_b1x_ff;
      endcase
      case (s8_hits_ff[3:2])
         2'b00:   s9_vy_in = s8_vy_ff;
         2'b11:   s9_vy_in = sat32(round_q16(s8_bby_ff));
         default: s9_vy_in = s8_b1y_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_px_ff <= req_ch.pos_x;
         s1_py_ff <= req_ch.pos_y;
         s1_vx_ff <= req_ch.vel_x;
         s1_vy_ff <= req_ch.vel_y;
         s1_ax_ff <= req_ch.acc_x;
         s1_ay_ff <= s1_ay_in;
         s1_r_ff  <= req_ch.radius;
      end
      if (adv[2]) begin
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_vx_ff  <= s1_vx_ff;
         s2_vy_ff  <= s1_vy_ff;
         s2_r_ff   <= s1_r_ff;
         s2_pax_ff <= s1_ax_ff * dt;
         s2_pay_ff <= s1_ay_ff * dt;
      end
      if (adv[3]) begin
         s3_px_ff <= s2_px_ff;
         s3_py_ff <= s2_py_ff;
         s3_vx_ff <= s3_vx_in;
         s3_vy_ff <= s3_vy_in;
         s3_r_ff  <= s2_r_ff;
      end
      if (adv[4]) begin
         s4_px_ff  <= s3_px_ff;
         s4_py_ff  <= s3_py_ff;
         s4_vx_ff  <= s3_vx_ff;
         s4_vy_ff  <= s3_vy_ff;
         s4_r_ff   <= s3_r_ff;
         s4_pvx_ff <= s3_vx_ff * dt;
         s4_pvy_ff <= s3_vy_ff * dt;
      end
      if (adv[5]) begin
         s5_px_ff <= s5_px_in;
         s5_py_ff <= s5_py_in;
         s5_vx_ff <= s4_vx_ff;
         s5_vy_ff <= s4_vy_ff;
         s5_r_ff  <= s4_r_ff;
      end
      if (adv[6]) begin
         s6_px_ff   <= s6_px_in;
         s6_py_ff   <= s6_py_in;
         s6_vx_ff   <= s5_vx_ff;
         s6_vy_ff   <= s5_vy_ff;
         s6_hits_ff <= s6_hits_in;
         s6_bx_ff   <= s5_vx_ff * NEG_INV_SQRT2;
         s6_by_ff   <= s5_vy_ff * NEG_INV_SQRT2;
      end
      if (adv[7]) begin
         s7_px_ff   <= s6_px_ff;
         s7_py_ff   <= s6_py_ff;
         s7_vx_ff   <= s6_vx_ff;
         s7_vy_ff   <= s6_vy_ff;
         s7_hits_ff <= s6_hits_ff;
         s7_b1x_ff  <= sat32(round_q16(s6_bx_ff));
         s7_b1y_ff  <= sat32(round_q16(s6_by_ff));
      end
      if (adv[8]) begin
         s8_px_ff   <= s7_px_ff;
         s8_py_ff   <= s7_py_ff;
         s8_vx_ff   <= s7_vx_ff;
         s8_vy_ff   <= s7_vy_ff;
         s8_hits_ff <= s7_hits_ff;
         s8_b1x_ff  <= s7_b1x_ff;
         s8_b1y_ff  <= s7_b1y_ff;
         s8_bbx_ff  <= s7_b1x_ff * NEG_INV_SQRT2;
         s8_bby_ff  <= s7_b1y_ff * NEG_INV_SQRT2;
      end
      if (adv[9]) begin
         s9_px_ff   <= s8_px_ff;
         s9_py_ff   <= s8_py_ff;
         s9_vx_ff   <= s9_vx_in;
         s9_vy_ff   <= s9_vy_in;
         s9_hits_ff <= s8_hits_ff;
      end
   end

   assign rsp_ch.valid     = valid_ff[NSTG];
   assign rsp_ch.new_pos_x = s9_px_ff;
   assign rsp_ch.new_pos_y = s9_py_ff;
   assign rsp_ch.new_vel_x = s9_vx_ff;
   assign rsp_ch.new_vel_y = s9_vy_ff;
   assign rsp_ch.wall_hits = s9_hits_ff;

endmodule
